// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
// Each macro checks on the rising edge of the given clock and is disabled
// while the active-low reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every checked edge.
`define ASSERT_PROP(lbl, clk_sig, rst_n_sig, prop) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) (prop)) \
		else $error("%m: property check failed");

// Condition must never be true at a checked edge.
`define ASSERT_NEVER(lbl, clk_sig, rst_n_sig, cond) \
	lbl: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) !(cond)) \
		else $error("%m: forbidden condition seen");

`else

`define ASSERT_PROP(lbl, clk_sig, rst_n_sig, prop)
`define ASSERT_NEVER(lbl, clk_sig, rst_n_sig, cond)

`endif

`endif

// File: hw/rtl/kfr_pkg.sv
package kfr_pkg;

	// Item kinds on the input channel
	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	// Field and register widths
	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned LIMIT_W   = 10;
	localparam int unsigned POS_W     = 3;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DAT_W = LIMIT_W;

	// Register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_MARKER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SECOND_MARKER = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LIMIT = 2'd2;

	// Register reset values
	localparam logic [BYTE_W-1:0]  FIRST_MARKER_RST  = 8'h50;
	localparam logic [BYTE_W-1:0]  SECOND_MARKER_RST = 8'h4C;
	localparam logic [LIMIT_W-1:0] TIMEOUT_LIMIT_RST = 10'd999;

	// Frame positions: header occupies 0..1, payload 2..3
	localparam logic [POS_W-1:0] POS_HUNT      = 3'd0;
	localparam logic [POS_W-1:0] POS_HEADER    = 3'd1;
	localparam logic [POS_W-1:0] POS_KEY       = 3'd2;
	localparam logic [POS_W-1:0] FRAME_LENGTH  = 3'd4;

endpackage

// File: hw/rtl/key_frame_receiver.sv
// Channel   | Handshake          | Payload
// ----------+--------------------+-----------------------------------------
// input     | in_valid, in_stall | opcode, rx_byte
// output    | out_valid,out_stall| key_value, frame_accepted, timed_out
// config    | cfg_wr_en          | cfg_index, cfg_data
//
// One result per input item, loaded into the result register on transfer.
// An item is taken every cycle that in_stall is low; the single state update
// (compares, 3- and 11-bit increments) sits between state and result regs.
// in_stall is raised only while a result waits under out_stall.
// arst_n clears all receiver state and reloads the register defaults.
`include "assert_macros.svh"

module key_frame_receiver (
	input  logic                                clk,
	input  logic                                arst_n,
	// input channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                opcode,
	input  logic [kfr_pkg::BYTE_W-1:0]          rx_byte,
	// output channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [kfr_pkg::BYTE_W-1:0]          key_value,
	output logic                                frame_accepted,
	output logic                                timed_out,
	// configuration
	input  logic                                cfg_wr_en,
	input  logic [kfr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [kfr_pkg::CFG_DAT_W-1:0]       cfg_data
);

	// Configuration registers
	logic [kfr_pkg::BYTE_W-1:0]  first_marker_q;
	logic [kfr_pkg::BYTE_W-1:0]  second_marker_q;
	logic [kfr_pkg::LIMIT_W-1:0] timeout_limit_q;

	// Receiver state
	logic                        header_seen_q;
	logic                        in_payload_q;
	logic [kfr_pkg::POS_W-1:0]   byte_pos_q;
	logic [kfr_pkg::BYTE_W-1:0]  held_byte_q;
	logic                        activity_q;
	logic [kfr_pkg::LIMIT_W-1:0] idle_ticks_q;
	logic [kfr_pkg::BYTE_W-1:0]  latched_key_q;

	// Result register
	logic                        out_valid_s1;
	logic [kfr_pkg::BYTE_W-1:0]  key_value_s1;
	logic                        frame_accepted_s1;
	logic                        timed_out_s1;

	// Next-state values
	logic                        header_seen_d;
	logic                        in_payload_d;
	logic [kfr_pkg::POS_W-1:0]   byte_pos_d;
	logic [kfr_pkg::BYTE_W-1:0]  held_byte_d;
	logic                        activity_d;
	logic [kfr_pkg::LIMIT_W-1:0] idle_ticks_d;
	logic [kfr_pkg::BYTE_W-1:0]  latched_key_d;
	logic                        accepted_d;
	logic                        expired_d;

	logic                        in_xfer;
	logic [kfr_pkg::POS_W-1:0]   pos_inc;
	logic [kfr_pkg::BYTE_W-1:0]  check_byte;
	logic [kfr_pkg::LIMIT_W:0]   idle_inc;

	// Hold the input while a result waits under stall
	assign in_stall = out_valid_s1 && out_stall;
	assign in_xfer  = in_valid && !in_stall;

	// Configuration writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_marker_q  <= kfr_pkg::FIRST_MARKER_RST;
			second_marker_q <= kfr_pkg::SECOND_MARKER_RST;
			timeout_limit_q <= kfr_pkg::TIMEOUT_LIMIT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				kfr_pkg::CFG_FIRST_MARKER:  first_marker_q  <= cfg_data[kfr_pkg::BYTE_W-1:0];
				kfr_pkg::CFG_SECOND_MARKER: second_marker_q <= cfg_data[kfr_pkg::BYTE_W-1:0];
				kfr_pkg::CFG_TIMEOUT_LIMIT: timeout_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Payload position and the byte the check is made against
	assign pos_inc  = byte_pos_q + kfr_pkg::POS_W'(1);
	assign check_byte = (byte_pos_q == kfr_pkg::POS_KEY) ? rx_byte : held_byte_q;
	assign idle_inc = {1'b0, idle_ticks_q} + (kfr_pkg::LIMIT_W+1)'(1);

	// Receiver update for one byte or one tick
	always_comb begin
		header_seen_d = header_seen_q;
		in_payload_d  = in_payload_q;
		byte_pos_d    = byte_pos_q;
		held_byte_d   = held_byte_q;
		activity_d    = activity_q;
		idle_ticks_d  = idle_ticks_q;
		latched_key_d = latched_key_q;
		accepted_d    = 1'b0;
		expired_d     = 1'b0;
		if (opcode == kfr_pkg::OP_BYTE) begin
			if (!in_payload_q) begin
				// hunt for the two-byte header, no resync on a bad second byte
				if (!header_seen_q && rx_byte == first_marker_q) begin
					header_seen_d = 1'b1;
					byte_pos_d    = kfr_pkg::POS_HEADER;
				end else if (header_seen_q) begin
					if (rx_byte == second_marker_q) begin
						in_payload_d = 1'b1;
						byte_pos_d   = kfr_pkg::POS_KEY;
					end else begin
						byte_pos_d = kfr_pkg::POS_HUNT;
					end
					header_seen_d = 1'b0;
				end else begin
					byte_pos_d = kfr_pkg::POS_HUNT;
				end
			end else begin
				// collect payload, check the complement on the last byte
				held_byte_d = check_byte;
				if (pos_inc >= kfr_pkg::FRAME_LENGTH) begin
					byte_pos_d   = kfr_pkg::POS_HUNT;
					in_payload_d = 1'b0;
					if (rx_byte == ~check_byte) begin
						latched_key_d = check_byte;
						accepted_d    = 1'b1;
					end
				end else begin
					byte_pos_d = pos_inc;
				end
			end
			activity_d   = 1'b1;
			idle_ticks_d = '0;
		end else begin
			// count idle ticks only once the line has seen a byte
			if (activity_q) begin
				if (idle_inc > {1'b0, timeout_limit_q}) begin
					idle_ticks_d  = '0;
					byte_pos_d    = kfr_pkg::POS_HUNT;
					header_seen_d = 1'b0;
					activity_d    = 1'b0;
					latched_key_d = '0;
					expired_d     = 1'b1;
				end else begin
					idle_ticks_d = idle_inc[kfr_pkg::LIMIT_W-1:0];
				end
			end else begin
				idle_ticks_d = '0;
			end
		end
	end

	// Advance receiver state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_seen_q <= 1'b0;
			in_payload_q  <= 1'b0;
			byte_pos_q    <= kfr_pkg::POS_HUNT;
			held_byte_q   <= '0;
			activity_q    <= 1'b0;
			idle_ticks_q  <= '0;
			latched_key_q <= '0;
		end else if (in_xfer) begin
			header_seen_q <= header_seen_d;
			in_payload_q  <= in_payload_d;
			byte_pos_q    <= byte_pos_d;
			held_byte_q   <= held_byte_d;
			activity_q    <= activity_d;
			idle_ticks_q  <= idle_ticks_d;
			latched_key_q <= latched_key_d;
		end
	end

	// Result register valid: load on transfer, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			out_valid_s1 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s1 <= 1'b0;
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			key_value_s1      <= latched_key_d;
			frame_accepted_s1 <= accepted_d;
			timed_out_s1      <= expired_d;
		end
	end

	assign out_valid      = out_valid_s1;
	assign key_value      = key_value_s1;
	assign frame_accepted = frame_accepted_s1;
	assign timed_out      = timed_out_s1;

	// A result is either a byte outcome or a tick outcome, never both
	`ASSERT_NEVER(a_accept_and_timeout, clk, arst_n,
		out_valid_s1 && frame_accepted_s1 && timed_out_s1)

	// The idle count only runs while the line is marked active
	`ASSERT_NEVER(a_idle_without_activity, clk, arst_n,
		idle_ticks_q != '0 && !activity_q)

	// The header flag and payload mode exclude each other
	`ASSERT_NEVER(a_header_in_payload, clk, arst_n,
		header_seen_q && in_payload_q)

	// A timeout clears the key and the activity flag
	`ASSERT_PROP(a_timeout_clears, clk, arst_n,
		in_xfer && expired_d |=> latched_key_q == '0 && !activity_q)

	// An accepted frame reports the byte that was held as key
	`ASSERT_PROP(a_accept_reports_key, clk, arst_n,
		out_valid_s1 && frame_accepted_s1 |-> key_value_s1 == held_byte_q)

endmodule

// File: sim/tb_key_frame_receiver.sv
module tb_key_frame_receiver;
	timeunit 1ns;
	timeprecision 1ps;

	import kfr_pkg::*;

	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int DRAIN_CYCLES    = 4;
	localparam int ITEMS_PER_PHASE = 115;
	localparam int NUM_PHASES      = 6;
	localparam int HOLD_CYCLES     = 64;

	// Index past the last register; writes there must be ignored
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [BYTE_W-1:0] key;
		logic              accepted;
		logic              expired;
	} key_report_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 opcode;
	logic [BYTE_W-1:0]    rx_byte;
	logic                 out_valid;
	logic                 out_stall;
	logic [BYTE_W-1:0]    key_value;
	logic                 frame_accepted;
	logic                 timed_out;
	logic                 cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	key_frame_receiver uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.opcode        (opcode),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.key_value     (key_value),
		.frame_accepted(frame_accepted),
		.timed_out     (timed_out),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// Predicted receiver state and register copies
	logic                 hdr_half;
	logic                 payload_mode;
	logic [POS_W-1:0]     frame_pos;
	logic [BYTE_W-1:0]    held_key;
	logic                 line_busy;
	logic [LIMIT_W-1:0]   idle_count;
	logic [BYTE_W-1:0]    key_now;
	logic [BYTE_W-1:0]    cfg_first;
	logic [BYTE_W-1:0]    cfg_second;
	logic [LIMIT_W-1:0]   cfg_limit;

	key_report_t pending_reports[$];
	int          errors;
	int          items_sent;
	int          quiet_cycles;
	bit          steady;
	bit          no_gaps;
	bit          holding;
	int          hold_request;

	logic [BYTE_W-1:0] phase_first  [NUM_PHASES] = '{8'h00, 8'hFF, 8'hA5, 8'h3C, 8'h50, 8'h7E};
	logic [BYTE_W-1:0] phase_second [NUM_PHASES] = '{8'hFF, 8'h00, 8'hA5, 8'hC3, 8'h4C, 8'h81};
	logic [LIMIT_W-1:0] phase_limit [NUM_PHASES] = '{10'd1, 10'd1023, 10'd0, 10'd7, 10'd999, 10'd20};

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void reset_predictor();
		hdr_half     = 1'b0;
		payload_mode = 1'b0;
		frame_pos    = POS_HUNT;
		held_key     = '0;
		line_busy    = 1'b0;
		idle_count   = '0;
		key_now      = '0;
		cfg_first    = FIRST_MARKER_RST;
		cfg_second   = SECOND_MARKER_RST;
		cfg_limit    = TIMEOUT_LIMIT_RST;
	endfunction

	function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		case (idx)
			CFG_FIRST_MARKER: begin
				cfg_first = data[BYTE_W-1:0];
			end
			CFG_SECOND_MARKER: begin
				cfg_second = data[BYTE_W-1:0];
			end
			CFG_TIMEOUT_LIMIT: begin
				cfg_limit = data[LIMIT_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Advance the predicted receiver by one item and return its report
	function automatic key_report_t step_receiver(input opcode_t op, input logic [BYTE_W-1:0] b);
		key_report_t      r;
		logic [POS_W-1:0] pos;
		logic [LIMIT_W:0] next;
		r.accepted = 1'b0;
		r.expired  = 1'b0;
		if (op == OP_BYTE) begin
			if (!payload_mode) begin
				// hunt for the header; a wrong second byte is not re-examined
				if (!hdr_half && b == cfg_first) begin
					hdr_half  = 1'b1;
					frame_pos = POS_HEADER;
				end else if (hdr_half) begin
					if (b == cfg_second) begin
						payload_mode = 1'b1;
						frame_pos    = POS_KEY;
					end else begin
						frame_pos = POS_HUNT;
					end
					hdr_half = 1'b0;
				end else begin
					frame_pos = POS_HUNT;
				end
			end else begin
				// hold the key byte, check the closing byte against its complement
				pos = frame_pos;
				if (pos == POS_KEY)
					held_key = b;
				pos = pos + 1'b1;
				if (pos >= FRAME_LENGTH) begin
					pos          = POS_HUNT;
					payload_mode = 1'b0;
					if (b == ~held_key) begin
						key_now    = held_key;
						r.accepted = 1'b1;
					end
				end
				frame_pos = pos;
			end
			line_busy  = 1'b1;
			idle_count = '0;
		end else begin
			// count idle ticks only while the line is active
			if (line_busy) begin
				next = {1'b0, idle_count} + 1'b1;
				if (next > {1'b0, cfg_limit}) begin
					idle_count = '0;
					frame_pos  = POS_HUNT;
					hdr_half   = 1'b0;
					line_busy  = 1'b0;
					key_now    = '0;
					r.expired  = 1'b1;
				end else begin
					idle_count = next[LIMIT_W-1:0];
				end
			end else begin
				idle_count = '0;
			end
		end
		r.key = key_now;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady || no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Offer one item, wait for the transfer, record its predicted report
	task automatic send_item(input opcode_t op, input logic [BYTE_W-1:0] b);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		rx_byte  <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		pending_reports.push_back(step_receiver(op, b));
		items_sent++;
	endtask

	task automatic send_byte(input logic [BYTE_W-1:0] b);
		send_item(OP_BYTE, b);
	endtask

	task automatic send_tick();
		logic [BYTE_W-1:0] filler;
		filler = BYTE_W'($urandom_range(0, 255));
		send_item(OP_TICK, filler);
	endtask

	task automatic send_frame(input logic [BYTE_W-1:0] k, input logic [BYTE_W-1:0] chk);
		send_byte(cfg_first);
		send_byte(cfg_second);
		send_byte(k);
		send_byte(chk);
	endtask

	// Drop valid and wait until every expected report has arrived
	task automatic wait_for_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_reports.size() != 0) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DAT_W-1:0] data);
		wait_for_idle();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		apply_register(idx, data);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	// Ticks straight after reset leave the idle count at zero
	task automatic test_idle_ticks();
		send_tick();
		send_tick();
	endtask

	// A good frame with key 00, a failed check with key FF, a wrong second byte
	task automatic test_header_and_check();
		send_frame(8'h00, 8'hFF);
		send_frame(8'hFF, 8'h01);
		send_byte(cfg_first);
		send_byte(cfg_first);
		send_byte(cfg_second);
	endtask

	// Time out in mid-payload with a zero limit, then frame across positions 0..3
	task automatic test_payload_after_timeout();
		write_register(CFG_TIMEOUT_LIMIT, 10'd0);
		send_byte(cfg_first);
		send_byte(cfg_second);
		send_tick();
		send_tick();
		send_byte(cfg_first);
		send_byte(cfg_second);
		send_byte(8'h33);
		send_byte(8'hCC);
	endtask

	// Lower the limit under the running count; the next tick clears
	task automatic test_limit_lowered();
		write_register(CFG_TIMEOUT_LIMIT, 10'd20);
		send_frame(8'h96, 8'h69);
		send_tick();
		send_tick();
		send_tick();
		write_register(CFG_TIMEOUT_LIMIT, 10'd1);
		send_tick();
	endtask

	// Upper data bits on marker writes and a write past the register list
	task automatic test_register_writes();
		write_register(CFG_FIRST_MARKER, 10'h381);
		write_register(CFG_SECOND_MARKER, 10'h218);
		write_register(CFG_TIMEOUT_LIMIT, 10'd1023);
		write_register(CFG_UNUSED, 10'h3FF);
		send_frame(8'hC3, 8'h3C);
	endtask

	// Hold off the receiver while the sender keeps offering items
	task automatic test_backpressure();
		wait_for_idle();
		hold_request = HOLD_CYCLES;
		while (!holding) @(posedge clk);
		no_gaps = 1'b1;
		repeat (6) send_frame(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
		no_gaps = 1'b0;
	endtask

	task automatic send_random_sequence();
		int                r;
		int                len;
		logic [BYTE_W-1:0] k;
		logic [BYTE_W-1:0] second;
		logic [BYTE_W-1:0] chk;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			// well-formed frame, mostly with a passing check
			k      = BYTE_W'($urandom_range(0, 255));
			second = ($urandom_range(0, 9) != 0) ? cfg_second : BYTE_W'($urandom_range(0, 255));
			chk    = ($urandom_range(0, 3) != 0) ? ~k : BYTE_W'($urandom_range(0, 255));
			send_byte(cfg_first);
			send_byte(second);
			send_byte(k);
			send_byte(chk);
		end else if (r < 75) begin
			// tick burst, sometimes exactly long enough to time out
			if (cfg_limit <= 10'd40 && $urandom_range(0, 3) == 0)
				len = int'(cfg_limit) + 1;
			else
				len = $urandom_range(1, (cfg_limit + 2 > 12) ? 12 : int'(cfg_limit) + 2);
			repeat (len) send_tick();
		end else if (r < 90) begin
			send_byte(BYTE_W'($urandom_range(0, 255)));
		end else begin
			// broken header
			send_byte(cfg_first);
			if ($urandom_range(0, 1) != 0)
				send_byte(cfg_first);
		end
	endtask

	task automatic test_random_phases();
		int       start;
		logic [1:0] junk;
		for (int p = 0; p < NUM_PHASES; p++) begin
			junk = 2'($urandom_range(0, 3));
			write_register(CFG_FIRST_MARKER, {junk, phase_first[p]});
			junk = 2'($urandom_range(0, 3));
			write_register(CFG_SECOND_MARKER, {junk, phase_second[p]});
			write_register(CFG_TIMEOUT_LIMIT, phase_limit[p]);
			steady = (p == 4);
			start  = items_sent;
			while (items_sent - start < ITEMS_PER_PHASE) send_random_sequence();
			steady = 1'b0;
		end
	endtask

	// Receiver side: random stalls, quiet stretches and requested hold-offs
	initial begin
		int len;
		int r;
		out_stall = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			holding = 1'b0;
			if (hold_request > 0) begin
				len          = hold_request;
				hold_request = 0;
				holding      = 1'b1;
				out_stall   <= 1'b1;
			end else if (steady) begin
				len        = 1;
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(0, 99);
				if (r < 55) begin
					len        = $urandom_range(1, 8);
					out_stall <= 1'b0;
				end else if (r < 92) begin
					len        = $urandom_range(1, 3);
					out_stall <= 1'b1;
				end else begin
					len        = $urandom_range(10, 40);
					out_stall <= 1'b1;
				end
			end
			repeat (len) @(negedge clk);
		end
	end

	// Compare each report transfer with the oldest prediction
	always @(posedge clk) begin
		key_report_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_reports.size() == 0) begin
				$error("report transfer with no prediction pending");
				errors++;
			end else begin
				want = pending_reports.pop_front();
				if (key_value !== want.key) begin
					$error("key_value: expected %0h, got %0h", want.key, key_value);
					errors++;
				end
				if (frame_accepted !== want.accepted) begin
					$error("frame_accepted: expected %0b, got %0b", want.accepted,
						frame_accepted);
					errors++;
				end
				if (timed_out !== want.expired) begin
					$error("timed_out: expected %0b, got %0b", want.expired, timed_out);
					errors++;
				end
			end
		end
	end

	// End the run if no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		opcode       = OP_BYTE;
		rx_byte      = '0;
		cfg_wr_en    = 1'b0;
		cfg_index    = CFG_FIRST_MARKER;
		cfg_data     = '0;
		errors       = 0;
		items_sent   = 0;
		quiet_cycles = 0;
		steady       = 1'b0;
		no_gaps      = 1'b0;
		holding      = 1'b0;
		hold_request = 0;
		reset_predictor();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_idle_ticks();
		test_header_and_check();
		test_payload_after_timeout();
		test_limit_lowered();
		test_register_writes();
		test_backpressure();
		test_random_phases();

		wait_for_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_reports.size() != 0) begin
			$error("%0d predicted reports never arrived", pending_reports.size());
			errors++;
		end
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
